/* rtl/alpha_ink_bounding_box_macros.svh */
// assertion macros for the alpha ink bounding box block
`ifndef ALPHA_INK_BOUNDING_BOX_MACROS_SVH
`define ALPHA_INK_BOUNDING_BOX_MACROS_SVH

`ifndef SYNTH

// condition that holds at every clock edge out of reset
`define AIBB_ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("aibb: invariant violated");

// implication checked in the same cycle
`define AIBB_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("aibb: same-cycle check failed");

// implication checked in the next cycle
`define AIBB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("aibb: next-cycle check failed");

`else

`define AIBB_ASSERT_ALWAYS(label, clk, rst, expr)
`define AIBB_ASSERT_SAME(label, clk, rst, ante, cons)
`define AIBB_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* rtl/aibb_pkg.sv */
package aibb_pkg;

  // fixed field widths
  localparam int PIXEL_W   = 32;
  localparam int ALPHA_LSB = 24;
  localparam int ALPHA_W   = 8;
  localparam int DIM_W     = 13;
  localparam int COORD_W   = 12;
  localparam int COUNT_W   = 23;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // result tdata: four coordinates and the count, padded to whole bytes
  localparam int OUT_RAW_W   = 4 * COORD_W + COUNT_W;
  localparam int OUT_TDATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 2'd2;

  // reset values and default frame limit
  localparam logic [ALPHA_W-1:0] THRESHOLD_RESET = '0;
  localparam logic [DIM_W-1:0]   DIM_RESET       = 13'd4096;
  localparam int                 MAX_DIM_DEFAULT = 4096;

endpackage

/* rtl/alpha_ink_bounding_box.sv */
// Alpha ink bounding box over a raster pixel stream.
// Input: s_axis carries one 32-bit ARGB pixel per transfer in raster order;
// the block counts columns and rows itself against image_width/image_height.
// Pixels on even column and even row are examined; alpha above the threshold
// is ink, and its min/max column, row and count are kept for the frame.
// Output: one m_axis transfer per frame, registered when the frame's last
// pixel is taken; tuser is the has-ink flag, tdata the widened, clamped box
// and the ink count (all zero when the frame had no ink).
// Throughput: one pixel per clock; each pixel passes one rank of compare and
// select logic between the frame state and the result register.
// Stalls: only the last pixel of a frame waits on the receiver, and only
// while the previous result has not been taken; every other pixel is taken
// even when a result is pending.
// Configuration: cfg writes are always ready and do not restart the frame;
// unknown indexes are dropped. A dimension of zero acts as one, above MAX_DIM
// as MAX_DIM.
// Reset: synchronous, clears the frame state and output valid, and returns
// threshold to 0 and both dimensions to 4096.
`include "alpha_ink_bounding_box_macros.svh"

module alpha_ink_bounding_box #(
  parameter int MAX_DIM = aibb_pkg::MAX_DIM_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [aibb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [aibb_pkg::DIM_W-1:0]        cfg_data,
  // pixel input
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [aibb_pkg::PIXEL_W-1:0]      s_axis_tdata,   // pixel_word
  // frame result
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // box_left, box_top, box_right, box_bottom, ink_count, zero padding
  output logic [aibb_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  output logic                              m_axis_tuser    // has_ink
);

  import aibb_pkg::*;

  localparam int CW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam logic [CW-1:0] DIM_LAST_MAX = CW'(MAX_DIM - 1);

  // configuration registers
  logic [ALPHA_W-1:0] ink_threshold;
  logic [DIM_W-1:0]   image_width;
  logic [DIM_W-1:0]   image_height;

  // frame state
  logic [CW-1:0]      column_counter;
  logic [CW-1:0]      row_counter;
  logic               seen_ink;
  logic [CW-1:0]      min_column;
  logic [CW-1:0]      min_row;
  logic [CW-1:0]      max_column;
  logic [CW-1:0]      max_row;
  logic [COUNT_W-1:0] hit_count;

  logic [CW-1:0]      width_last;
  logic [CW-1:0]      height_last;
  logic               row_end;
  logic               frame_end;
  logic               in_xfer;
  logic               examine;

  logic               seen_ink_next;
  logic [CW-1:0]      min_column_next;
  logic [CW-1:0]      min_row_next;
  logic [CW-1:0]      max_column_next;
  logic [CW-1:0]      max_row_next;
  logic [COUNT_W-1:0] hit_count_next;

  logic [CW:0]        right_ext;
  logic [CW:0]        bottom_ext;
  logic [CW-1:0]      left_val;
  logic [CW-1:0]      top_val;
  logic [CW-1:0]      right_val;
  logic [CW-1:0]      bottom_val;
  logic [OUT_RAW_W-1:0] result_raw;

  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      ink_threshold <= THRESHOLD_RESET;
      image_width   <= DIM_RESET;
      image_height  <= DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_THRESHOLD: ink_threshold <= cfg_data[ALPHA_W-1:0];
        CFG_WIDTH:     image_width   <= cfg_data;
        CFG_HEIGHT:    image_height  <= cfg_data;
        default:       ;
      endcase
    end
  end

  // last column and row index after clamping the dimensions
  always_comb begin
    if (image_width == '0) begin
      width_last = '0;
    end else if (32'(image_width) > 32'(MAX_DIM)) begin
      width_last = DIM_LAST_MAX;
    end else begin
      width_last = CW'(image_width - 1'b1);
    end
    if (image_height == '0) begin
      height_last = '0;
    end else if (32'(image_height) > 32'(MAX_DIM)) begin
      height_last = DIM_LAST_MAX;
    end else begin
      height_last = CW'(image_height - 1'b1);
    end
  end

  assign row_end   = (column_counter >= width_last);
  assign frame_end = row_end && (row_counter >= height_last);

  // only the frame's last pixel waits for the result register to free up
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready || !frame_end;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  assign examine = !column_counter[0] && !row_counter[0] &&
                   (s_axis_tdata[ALPHA_LSB +: ALPHA_W] > ink_threshold);

  // box and count update for this pixel
  always_comb begin
    seen_ink_next   = seen_ink;
    min_column_next = min_column;
    min_row_next    = min_row;
    max_column_next = max_column;
    max_row_next    = max_row;
    hit_count_next  = hit_count;
    if (examine) begin
      seen_ink_next = 1'b1;
      if (!seen_ink) begin
        min_column_next = column_counter;
        max_column_next = column_counter;
        min_row_next    = row_counter;
        max_row_next    = row_counter;
      end else begin
        if (column_counter < min_column) min_column_next = column_counter;
        if (column_counter > max_column) max_column_next = column_counter;
        if (row_counter < min_row)       min_row_next    = row_counter;
        if (row_counter > max_row)       max_row_next    = row_counter;
      end
      if (hit_count != COUNT_MAX) hit_count_next = hit_count + 1'b1;
    end
  end

  // widened box, clamped to the image
  always_comb begin
    right_ext  = {1'b0, max_column_next} + 1'b1;
    bottom_ext = {1'b0, max_row_next} + 1'b1;
    left_val   = (min_column_next == '0) ? '0 : min_column_next - 1'b1;
    top_val    = (min_row_next == '0) ? '0 : min_row_next - 1'b1;
    right_val  = (right_ext > {1'b0, width_last}) ? width_last : right_ext[CW-1:0];
    bottom_val = (bottom_ext > {1'b0, height_last}) ? height_last : bottom_ext[CW-1:0];
    if (seen_ink_next) begin
      result_raw = {hit_count_next, COORD_W'(bottom_val), COORD_W'(right_val),
                    COORD_W'(top_val), COORD_W'(left_val)};
    end else begin
      result_raw = '0;
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      column_counter <= '0;
      row_counter    <= '0;
      seen_ink       <= 1'b0;
      min_column     <= '0;
      min_row        <= '0;
      max_column     <= '0;
      max_row        <= '0;
      hit_count      <= '0;
    end else if (in_xfer) begin
      if (frame_end) begin
        column_counter <= '0;
        row_counter    <= '0;
        seen_ink       <= 1'b0;
        min_column     <= '0;
        min_row        <= '0;
        max_column     <= '0;
        max_row        <= '0;
        hit_count      <= '0;
      end else begin
        if (row_end) begin
          column_counter <= '0;
          row_counter    <= row_counter + 1'b1;
        end else begin
          column_counter <= column_counter + 1'b1;
        end
        seen_ink   <= seen_ink_next;
        min_column <= min_column_next;
        min_row    <= min_row_next;
        max_column <= max_column_next;
        max_row    <= max_row_next;
        hit_count  <= hit_count_next;
      end
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_xfer && frame_end) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_xfer && frame_end) begin
      m_axis_tdata <= OUT_TDATA_W'(result_raw);
      m_axis_tuser <= seen_ink_next;
    end
  end

  // checks
  `AIBB_ASSERT_ALWAYS(a_count_matches_seen, clk, rst, seen_ink == (hit_count != '0))
  `AIBB_ASSERT_SAME(a_no_ink_zero_result, clk, rst, m_axis_tvalid && !m_axis_tuser,
                    m_axis_tdata == '0)
  `AIBB_ASSERT_NEXT(a_frame_end_gives_result, clk, rst, in_xfer && frame_end,
                    m_axis_tvalid)
  `AIBB_ASSERT_NEXT(a_frame_end_clears, clk, rst, in_xfer && frame_end,
                    column_counter == '0 && row_counter == '0 && !seen_ink)

endmodule

/* tb/sv/alpha_ink_bounding_box_checker.sv */
`timescale 1ns / 1ps

module alpha_ink_bounding_box_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [aibb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [aibb_pkg::DIM_W-1:0]          cfg_data,
  input  logic                                s_axis_tvalid,
  input  logic                                s_axis_tready,
  input  logic [aibb_pkg::PIXEL_W-1:0]        s_axis_tdata,   // pixel_word
  input  logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // box_left, box_top, box_right, box_bottom, ink_count, zero padding
  input  logic [aibb_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input  logic                                m_axis_tuser,   // has_ink
  output int                                  failures,
  output int                                  results_outstanding
);
  import aibb_pkg::*;

  typedef struct packed {
    logic               has_ink;
    logic [COORD_W-1:0] box_left;
    logic [COORD_W-1:0] box_top;
    logic [COORD_W-1:0] box_right;
    logic [COORD_W-1:0] box_bottom;
    logic [COUNT_W-1:0] ink_count;
  } frame_box_t;

  // register copies
  logic [ALPHA_W-1:0] threshold;
  logic [DIM_W-1:0]   width_reg;
  logic [DIM_W-1:0]   height_reg;

  // frame scan state
  logic [COORD_W-1:0] col;
  logic [COORD_W-1:0] row;
  logic               seen;
  logic [COORD_W-1:0] min_col;
  logic [COORD_W-1:0] min_row;
  logic [COORD_W-1:0] max_col;
  logic [COORD_W-1:0] max_row;
  logic [COUNT_W-1:0] hits;

  frame_box_t expected_boxes[$];
  int         fail_count = 0;

  // zero acts as one, oversize as the frame limit
  function automatic int active_dim(logic [DIM_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > MAX_DIM_DEFAULT) return MAX_DIM_DEFAULT;
    return int'(v);
  endfunction

  function automatic void clear_scan();
    col     = '0;
    row     = '0;
    seen    = 1'b0;
    min_col = '0;
    min_row = '0;
    max_col = '0;
    max_row = '0;
    hits    = '0;
  endfunction

  // advance the raster position and queue the box at the end of a frame
  function automatic void track_pixel(logic [PIXEL_W-1:0] px);
    int               w;
    int               h;
    int               c;
    int               r;
    int               right_edge;
    int               bottom_edge;
    logic [ALPHA_W-1:0] alpha;
    bit               row_end;
    bit               frame_end;
    frame_box_t       box;
    w         = active_dim(width_reg);
    h         = active_dim(height_reg);
    c         = int'(col);
    r         = int'(row);
    alpha     = px[ALPHA_LSB +: ALPHA_W];
    row_end   = c >= w - 1;
    frame_end = row_end && (r >= h - 1);

    // only even column, even row is examined
    if (!col[0] && !row[0] && alpha > threshold) begin
      if (!seen) begin
        min_col = col;
        max_col = col;
        min_row = row;
        max_row = row;
        seen    = 1'b1;
      end else begin
        if (col < min_col) min_col = col;
        if (col > max_col) max_col = col;
        if (row < min_row) min_row = row;
        if (row > max_row) max_row = row;
      end
      if (hits != COUNT_MAX) hits = hits + 1'b1;
    end

    if (!frame_end) begin
      if (row_end) begin
        col = '0;
        row = row + 1'b1;
      end else begin
        col = col + 1'b1;
      end
      return;
    end

    // widened box, clamped with the dimensions in force now
    box = '0;
    if (seen) begin
      right_edge  = int'(max_col) + 1;
      bottom_edge = int'(max_row) + 1;
      if (right_edge > w - 1) right_edge = w - 1;
      if (bottom_edge > h - 1) bottom_edge = h - 1;
      box.has_ink    = 1'b1;
      box.box_left   = (min_col == '0) ? '0 : min_col - 1'b1;
      box.box_top    = (min_row == '0) ? '0 : min_row - 1'b1;
      box.box_right  = right_edge[COORD_W-1:0];
      box.box_bottom = bottom_edge[COORD_W-1:0];
      box.ink_count  = hits;
    end
    expected_boxes.push_back(box);
    clear_scan();
  endfunction

  function automatic void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  function automatic void check_result();
    frame_box_t want;
    if (expected_boxes.size() == 0) begin
      $error("frame result transfer with no frame outstanding");
      fail_count++;
      return;
    end
    want = expected_boxes.pop_front();
    compare_field("has_ink", 32'(want.has_ink), 32'(m_axis_tuser));
    compare_field("box_left", 32'(want.box_left), 32'(m_axis_tdata[0 +: COORD_W]));
    compare_field("box_top", 32'(want.box_top), 32'(m_axis_tdata[COORD_W +: COORD_W]));
    compare_field("box_right", 32'(want.box_right),
                  32'(m_axis_tdata[2*COORD_W +: COORD_W]));
    compare_field("box_bottom", 32'(want.box_bottom),
                  32'(m_axis_tdata[3*COORD_W +: COORD_W]));
    compare_field("ink_count", 32'(want.ink_count),
                  32'(m_axis_tdata[4*COORD_W +: COUNT_W]));
  endfunction

  // watch all three channels; results first, as they come from older pixels,
  // and register writes last, as a pixel in the same cycle sees the old values
  always @(posedge clk) begin
    if (rst) begin
      threshold  = THRESHOLD_RESET;
      width_reg  = DIM_RESET;
      height_reg = DIM_RESET;
      clear_scan();
      expected_boxes.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (s_axis_tvalid && s_axis_tready) track_pixel(s_axis_tdata);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_THRESHOLD: threshold = cfg_data[ALPHA_W-1:0];
          CFG_WIDTH:     width_reg = cfg_data;
          CFG_HEIGHT:    height_reg = cfg_data;
          default: ;
        endcase
      end
    end
    failures            <= fail_count;
    results_outstanding <= expected_boxes.size();
  end

endmodule

/* tb/sv/alpha_ink_bounding_box_tb.sv */
`timescale 1ns / 1ps

module alpha_ink_bounding_box_tb;
  import aibb_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_PIXELS  = 1380;
  localparam int HOLD_CYCLES    = 300;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // 3x3 frame, threshold 0: ink on the top-left and bottom-right examined pixels
  localparam logic [PIXEL_W-1:0] CORNER_FRAME [9] = '{
    32'h0100_0000, 32'hFFFF_FFFF, 32'h00FF_FFFF,
    32'hFFFF_FFFF, 32'hFF00_0000, 32'h8055_AA55,
    32'h0000_0000, 32'h7FAA_55AA, 32'hFFFF_FFFF
  };
  // 4x4 frame, threshold 0x80, cut short by a resize after six pixels
  localparam logic [PIXEL_W-1:0] RESIZE_FRAME [7] = '{
    32'h8012_3456, 32'hFF00_0000, 32'h8165_4321, 32'h0000_0000,
    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF
  };

  logic                       clk           = 1'b0;
  logic                       rst           = 1'b1;
  logic                       cfg_valid     = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index     = '0;
  logic [DIM_W-1:0]           cfg_data      = '0;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  logic [PIXEL_W-1:0]         s_axis_tdata  = '0;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]     m_axis_tdata;
  logic                       m_axis_tuser;

  int failures;
  int results_outstanding;
  int hold_requests = 0;
  int idle_cycles   = 0;

  // settings currently written, for stimulus shaping
  logic [ALPHA_W-1:0] cur_threshold = THRESHOLD_RESET;
  logic [DIM_W-1:0]   cur_width     = DIM_RESET;
  logic [DIM_W-1:0]   cur_height    = DIM_RESET;

  alpha_ink_bounding_box u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  alpha_ink_bounding_box_checker u_checker (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .s_axis_tvalid       (s_axis_tvalid),
    .s_axis_tready       (s_axis_tready),
    .s_axis_tdata        (s_axis_tdata),
    .m_axis_tvalid       (m_axis_tvalid),
    .m_axis_tready       (m_axis_tready),
    .m_axis_tdata        (m_axis_tdata),
    .m_axis_tuser        (m_axis_tuser),
    .failures            (failures),
    .results_outstanding (results_outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // stop when no channel has moved for too long
  always @(posedge clk) begin
    if (rst || (cfg_valid && cfg_ready) || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result receiver: random stalls, quiet stretches, and one long hold-off on request
  initial begin
    int stall;
    int quiet;
    int holds_served;
    quiet        = 0;
    holds_served = 0;
    while (rst) @(posedge clk);
    forever begin
      if (quiet > 0) begin
        stall = 0;
        quiet--;
      end else if ($urandom_range(0, 19) == 0) begin
        stall = 0;
        quiet = $urandom_range(10, 30);
      end else begin
        stall = $urandom_range(0, 14);
      end
      if (hold_requests != holds_served) begin
        holds_served++;
        stall = HOLD_CYCLES;
      end
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  function automatic int frame_dim(logic [DIM_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > MAX_DIM_DEFAULT) return MAX_DIM_DEFAULT;
    return int'(v);
  endfunction

  function automatic int frame_pixels();
    return frame_dim(cur_width) * frame_dim(cur_height);
  endfunction

  // random pixel with its alpha steered around the threshold
  function automatic logic [PIXEL_W-1:0] make_pixel(int ink_pct);
    logic [PIXEL_W-1:0] px;
    int                 a;
    px = $urandom;
    if (ink_pct == 0) begin
      a = $urandom_range(0, cur_threshold);
    end else begin
      case ($urandom_range(0, 7))
        0: a = int'(cur_threshold);
        1: a = int'(cur_threshold) + 1;
        2: a = int'(px[31:24]);
        default: begin
          if (cur_threshold != 8'hFF && $urandom_range(1, 100) <= ink_pct)
            a = $urandom_range(cur_threshold + 1, 255);
          else
            a = $urandom_range(0, cur_threshold);
        end
      endcase
    end
    px[ALPHA_LSB +: ALPHA_W] = a[ALPHA_W-1:0];
    return px;
  endfunction

  function automatic logic [ALPHA_W-1:0] pick_threshold();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return ALPHA_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic int pick_density();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 5;
      2:       return 30;
      default: return 90;
    endcase
  endfunction

  // one pixel transfer; valid stays high afterwards until the next gap
  task automatic send_pixel(logic [PIXEL_W-1:0] px, bit gaps_on);
    int gap;
    gap = gaps_on ? $urandom_range(0, 14) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic send_frame(int ink_pct, bit gaps_on);
    repeat (frame_pixels()) send_pixel(make_pixel(ink_pct), gaps_on);
  endtask

  // stop sending and let every outstanding frame result come back
  task automatic wait_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (results_outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure_frame(logic [ALPHA_W-1:0] thr, logic [DIM_W-1:0] w,
                                 logic [DIM_W-1:0] h);
    wait_results();
    write_reg(CFG_THRESHOLD, {{(DIM_W-ALPHA_W){1'b0}}, thr});
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    cur_threshold = thr;
    cur_width     = w;
    cur_height    = h;
  endtask

  // main stimulus
  initial begin
    int random_pixels;
    int phase;
    int n_frames;
    random_pixels = 0;
    phase         = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ink in both corners, widened box clamped on all sides
    configure_frame(8'h00, 13'd3, 13'd3);
    for (int i = 0; i < 9; i++) send_pixel(CORNER_FRAME[i], 1'b1);

    // unknown register index must be dropped
    wait_results();
    write_reg(CFG_UNUSED, 13'h1FFF);
    write_reg(CFG_UNUSED, 13'h0000);

    // threshold at its top: alpha equal to it is no ink, result all zero
    configure_frame(8'hFF, 13'd2, 13'd2);
    repeat (4) send_pixel(32'hFFFF_FFFF, 1'b1);

    // shrink width and height mid-frame: the next pixel closes the frame
    configure_frame(8'h80, 13'd4, 13'd4);
    for (int i = 0; i < 6; i++) send_pixel(RESIZE_FRAME[i], 1'b1);
    configure_frame(8'h80, 13'd2, 13'd2);
    send_pixel(RESIZE_FRAME[6], 1'b1);

    // random phases of small frames
    while (random_pixels < RANDOM_PIXELS) begin
      if (phase == 4) begin
        // one-pixel frames against a long receiver hold-off
        configure_frame(pick_threshold(), 13'd1, 13'd1);
        hold_requests <= hold_requests + 1;
        repeat (12) send_frame(50, 1'b0);
        random_pixels += 12;
      end else begin
        configure_frame(pick_threshold(), DIM_W'($urandom_range(0, 10)),
                        DIM_W'($urandom_range(0, 8)));
        n_frames = $urandom_range(1, 5);
        repeat (n_frames) begin
          send_frame(pick_density(), $urandom_range(0, 3) != 0);
          random_pixels += frame_pixels();
        end
      end
      phase++;
    end

    // oversize width with zero height, then a resize to one pixel closes the row
    configure_frame(pick_threshold(), 13'h1FFF, 13'd0);
    repeat (6) send_pixel(make_pixel(50), 1'b1);
    configure_frame(cur_threshold, 13'd0, 13'd0);
    send_pixel(make_pixel(50), 1'b1);

    // zero width with oversize height, then a resize to one row closes the column
    configure_frame(pick_threshold(), 13'd0, 13'd5000);
    repeat (6) send_pixel(make_pixel(50), 1'b1);
    configure_frame(cur_threshold, 13'd0, 13'd0);
    send_pixel(make_pixel(50), 1'b1);

    wait_results();
    repeat (10) @(posedge clk);
    if (failures == 0 && results_outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
